// ===== hw/rtl/parsimony_column_classifier_top_macros.svh =====
// Assertion macros shared by the column classifier RTL.
// Needs clk and rst_n in the scope of each use; bodies drop out under SYNTH.
`ifndef PARSIMONY_COLUMN_CLASSIFIER_TOP_MACROS_SVH
`define PARSIMONY_COLUMN_CLASSIFIER_TOP_MACROS_SVH

`ifndef SYNTH
// Check cons in the same cycle as ante.
`define PCC_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcc assertion failed");
// Check cons in the cycle after ante.
`define PCC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcc assertion failed");
`else
`define PCC_ASSERT_IMP(name, ante, cons)
`define PCC_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// ===== hw/rtl/pcc_pkg.sv =====
// Shared widths, codes and the column summary type for the column classifier.
// No dependencies; imported by every module of the block.
`default_nettype none

package pcc_pkg;

    // Field widths
    localparam int CODE_W   = 21;
    localparam int WEIGHT_W = 16;
    localparam int COST_W   = 8;
    localparam int OFFSET_W = 32;
    localparam int PROD_W   = WEIGHT_W + COST_W;

    // Column geometry
    localparam int N_STATES = 20;
    localparam int MAX_TAXA = 256;
    localparam int TAXA_W   = $clog2(MAX_TAXA + 1);

    // Summary queue between front and back; depth is a power of two
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // State masks and gap codes per alphabet
    localparam logic [N_STATES-1:0] AA_STATE_MASK = 20'hFFFFF;
    localparam logic [N_STATES-1:0] NT_STATE_MASK = 20'h0000F;
    localparam logic [CODE_W-1:0]   AA_GAP_CODE   = 21'h1FFFFF;
    localparam logic [CODE_W-1:0]   NT_GAP_CODE   = 21'h00001F;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SEQ_IS_PROTEIN   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_INFORMATIVE_ONLY = 1'b1;

    // One closed column, handed from front to back
    typedef struct packed {
        logic                keep;
        logic                undet;
        logic                inform;
        logic                drop;
        logic                fresh;
        logic [COST_W-1:0]   cost;
        logic [WEIGHT_W-1:0] weight;
    } summary_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pcc_front.sv =====
// Front end: takes one taxon beat per cycle while the queue is not full, folds counts
// and the Fitch set, and pushes a column summary on the last taxon. Uses pcc_pkg and the macros.
`default_nettype none
`include "parsimony_column_classifier_top_macros.svh"

module pcc_front
    import pcc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                seq_is_protein,
    input  logic                informative_only,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CODE_W-1:0]   taxon_code,
    input  logic [WEIGHT_W-1:0] column_weight,
    input  logic                last_taxon,
    input  logic                new_alignment,
    input  logic                q_full,
    output logic                push,
    output summary_t            summary
);

    logic [1:0]          cnt_reg [N_STATES];
    logic [1:0]          cnt_next [N_STATES];
    logic [1:0]          rep_reg, rep_next;
    logic                any_unamb_reg, any_unamb_next;
    logic                any_state_reg, any_state_next;
    logic [CODE_W-1:0]   fitch_set_reg, fitch_set_next;
    logic                started_reg, started_next;
    logic [COST_W-1:0]   changes_reg, changes_next;
    logic [TAXA_W-1:0]   taxa_reg;
    logic                fresh_reg;

    logic                in_fire;
    logic                counted;
    logic [N_STATES-1:0] alpha_mask;
    logic [CODE_W-1:0]   gap_code;
    logic [N_STATES-1:0] bits;
    logic                nonzero;
    logic                one_hot;
    logic                rep_hit;
    logic                is_gap;
    logic                fold;

    assign in_ready = !q_full;
    assign in_fire  = in_valid && in_ready;
    assign counted  = taxa_reg < TAXA_W'(MAX_TAXA);

    // Decode the state bits of the current alphabet
    assign alpha_mask = seq_is_protein ? AA_STATE_MASK : NT_STATE_MASK;
    assign gap_code   = seq_is_protein ? AA_GAP_CODE : NT_GAP_CODE;
    assign bits       = taxon_code[N_STATES-1:0] & alpha_mask;
    assign nonzero    = bits != '0;
    assign one_hot    = nonzero && ((bits & (bits - N_STATES'(1))) == '0);
    assign is_gap     = taxon_code == gap_code;
    assign fold       = counted && !is_gap;

    // Bump the saturating count of an unambiguous state
    always_comb
    begin
        rep_hit = 1'b0;
        for (int i = 0; i < N_STATES; i++)
        begin
            cnt_next[i] = cnt_reg[i];
            if (counted && one_hot && bits[i])
            begin
                if (cnt_reg[i] != 2'd3)
                begin
                    cnt_next[i] = cnt_reg[i] + 2'd1;
                end
                if (cnt_reg[i] == 2'd1)
                begin
                    rep_hit = 1'b1;
                end
            end
        end
    end

    // Track states seen twice, saturating at two
    assign rep_next       = (rep_hit && rep_reg != 2'd2) ? rep_reg + 2'd1 : rep_reg;
    assign any_unamb_next = any_unamb_reg || (counted && one_hot);
    assign any_state_next = any_state_reg || (counted && nonzero);

    // Fold the Fitch set left to right over non-gap taxa
    always_comb
    begin
        fitch_set_next = fitch_set_reg;
        started_next   = started_reg;
        changes_next   = changes_reg;
        if (fold)
        begin
            if (!started_reg)
            begin
                fitch_set_next = taxon_code;
                started_next   = 1'b1;
            end
            else if ((fitch_set_reg & taxon_code) == '0)
            begin
                fitch_set_next = fitch_set_reg | taxon_code;
                if (changes_reg != '1)
                begin
                    changes_next = changes_reg + COST_W'(1);
                end
            end
            else
            begin
                fitch_set_next = fitch_set_reg & taxon_code;
            end
        end
    end

    // Build the column summary from the updated state
    always_comb
    begin
        summary.undet  = !any_state_next;
        summary.inform = !any_unamb_next || (rep_next == 2'd2);
        summary.keep   = !summary.undet && (!informative_only || summary.inform);
        summary.drop   = !summary.undet && informative_only && !summary.inform;
        summary.fresh  = fresh_reg || new_alignment;
        summary.cost   = changes_next;
        summary.weight = column_weight;
    end

    assign push = in_fire && last_taxon;

    // Advance column state; clear it when the column closes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N_STATES; i++)
            begin
                cnt_reg[i] <= '0;
            end
            rep_reg       <= '0;
            any_unamb_reg <= 1'b0;
            any_state_reg <= 1'b0;
            fitch_set_reg <= '0;
            started_reg   <= 1'b0;
            changes_reg   <= '0;
            taxa_reg      <= '0;
            fresh_reg     <= 1'b0;
        end
        else if (in_fire)
        begin
            if (last_taxon)
            begin
                for (int i = 0; i < N_STATES; i++)
                begin
                    cnt_reg[i] <= '0;
                end
                rep_reg       <= '0;
                any_unamb_reg <= 1'b0;
                any_state_reg <= 1'b0;
                fitch_set_reg <= '0;
                started_reg   <= 1'b0;
                changes_reg   <= '0;
                taxa_reg      <= '0;
                fresh_reg     <= 1'b0;
            end
            else
            begin
                for (int i = 0; i < N_STATES; i++)
                begin
                    cnt_reg[i] <= cnt_next[i];
                end
                rep_reg       <= rep_next;
                any_unamb_reg <= any_unamb_next;
                any_state_reg <= any_state_next;
                fitch_set_reg <= fitch_set_next;
                started_reg   <= started_next;
                changes_reg   <= changes_next;
                taxa_reg      <= counted ? taxa_reg + TAXA_W'(1) : taxa_reg;
                fresh_reg     <= fresh_reg || new_alignment;
            end
        end
    end

    `PCC_ASSERT_IMP(a_push_room, push, !q_full)
    `PCC_ASSERT_IMP(a_taxa_bound, 1'b1, taxa_reg <= TAXA_W'(MAX_TAXA))
    `PCC_ASSERT_NEXT(a_column_clear, push, taxa_reg == '0 && !started_reg && rep_reg == '0)

endmodule

`default_nettype wire

// ===== hw/rtl/pcc_queue.sv =====
// Short summary queue between the front and back ends.
// Uses pcc_pkg for the entry type and depth.
`default_nettype none

module pcc_queue
    import pcc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  summary_t push_data,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output summary_t head
);

    summary_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full       = count_reg == QCNT_W'(QDEPTH);
    assign head_valid = count_reg != '0;
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Store an entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pcc_back.sv =====
// Back end: weights the cost of dropped columns, folds the saturating offset
// and holds the result beat. Uses pcc_pkg and the macros.
`default_nettype none
`include "parsimony_column_classifier_top_macros.svh"

module pcc_back
    import pcc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  summary_t            q_head,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                keep_column,
    output logic                undetermined,
    output logic                informative,
    output logic [COST_W-1:0]   column_cost,
    output logic [OFFSET_W-1:0] cost_offset
);

    logic                s1_valid_reg;
    logic                s1_keep_reg;
    logic                s1_undet_reg;
    logic                s1_inform_reg;
    logic                s1_drop_reg;
    logic                s1_fresh_reg;
    logic [COST_W-1:0]   s1_cost_reg;
    logic [PROD_W-1:0]   s1_prod_reg;
    logic [PROD_W-1:0]   prod;

    logic                out_valid_reg;
    logic                keep_reg;
    logic                undet_reg;
    logic                inform_reg;
    logic [COST_W-1:0]   cost_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic [OFFSET_W-1:0] offset_next;
    logic [OFFSET_W-1:0] base;
    logic [OFFSET_W:0]   sum;

    logic                out_load;
    logic                s1_ready;

    assign out_load = s1_valid_reg && (!out_valid_reg || out_ready);
    assign s1_ready = !s1_valid_reg || out_load;
    assign q_pop    = q_valid && s1_ready;

    // Weight the cost only for a dropped column
    assign prod = q_head.drop ? PROD_W'(q_head.weight) * PROD_W'(q_head.cost) : '0;

    // Stage one: register the product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_keep_reg   <= q_head.keep;
            s1_undet_reg  <= q_head.undet;
            s1_inform_reg <= q_head.inform;
            s1_drop_reg   <= q_head.drop;
            s1_fresh_reg  <= q_head.fresh;
            s1_cost_reg   <= q_head.cost;
            s1_prod_reg   <= prod;
        end
    end

    // Add to the offset, or start from zero on a fresh alignment, and saturate at all ones
    assign base        = s1_fresh_reg ? '0 : offset_reg;
    assign sum         = {1'b0, base} + (OFFSET_W + 1)'(s1_prod_reg);
    assign offset_next = sum[OFFSET_W] ? '1 : sum[OFFSET_W-1:0];

    // Stage two: hold the result beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            offset_reg    <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                offset_reg    <= offset_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            keep_reg   <= s1_keep_reg;
            undet_reg  <= s1_undet_reg;
            inform_reg <= s1_inform_reg;
            cost_reg   <= s1_cost_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign keep_column  = keep_reg;
    assign undetermined = undet_reg;
    assign informative  = inform_reg;
    assign column_cost  = cost_reg;
    assign cost_offset  = offset_reg;

    `PCC_ASSERT_IMP(a_keep_determined, out_valid_reg, !(keep_reg && undet_reg))
    `PCC_ASSERT_IMP(a_kept_no_cost, out_load && !s1_drop_reg && !s1_fresh_reg, offset_next == offset_reg)
    `PCC_ASSERT_NEXT(a_offset_grows, out_load && !s1_fresh_reg, offset_reg >= $past(offset_reg))

endmodule

`default_nettype wire

// ===== hw/rtl/parsimony_column_classifier_top.sv =====
// A column's summary is queued, then registered in stage one and the output stage.
// Throughput: one taxon beat per cycle, one column result per cycle when unstalled;
// the front takes a beat whenever the two-entry summary queue has room.
// Reset (rst_n, asynchronous, active low) clears column state, the offset, the
// queue and the output; seq_is_protein resets to 0 and informative_only to 1.
`default_nettype none

module parsimony_column_classifier_top
    import pcc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CODE_W-1:0]    taxon_code,
    input  logic [WEIGHT_W-1:0]  column_weight,
    input  logic                 last_taxon,
    input  logic                 new_alignment,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 keep_column,
    output logic                 undetermined,
    output logic                 informative,
    output logic [COST_W-1:0]    column_cost,
    output logic [OFFSET_W-1:0]  cost_offset
);

    logic     seq_is_protein_reg;
    logic     informative_only_reg;
    logic     push;
    summary_t push_data;
    logic     q_full;
    logic     q_pop;
    logic     q_valid;
    summary_t q_head;

    assign cfg_ready = 1'b1;

    // Decode configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_is_protein_reg   <= 1'b0;
            informative_only_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SEQ_IS_PROTEIN:   seq_is_protein_reg   <= cfg_data;
                REG_INFORMATIVE_ONLY: informative_only_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    pcc_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .seq_is_protein   (seq_is_protein_reg),
        .informative_only (informative_only_reg),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .taxon_code       (taxon_code),
        .column_weight    (column_weight),
        .last_taxon       (last_taxon),
        .new_alignment    (new_alignment),
        .q_full           (q_full),
        .push             (push),
        .summary          (push_data)
    );

    pcc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    pcc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .keep_column  (keep_column),
        .undetermined (undetermined),
        .informative  (informative),
        .column_cost  (column_cost),
        .cost_offset  (cost_offset)
    );

endmodule

`default_nettype wire
